>>> rtl/omni_three_wheel_kinematics_macros.svh
// assertion macros shared by the kinematics checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef OMNI_THREE_WHEEL_KINEMATICS_MACROS_SVH
`define OMNI_THREE_WHEEL_KINEMATICS_MACROS_SVH

// checked only outside reset
`define OTWK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define OTWK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/otwk_pkg.sv
// constants for the three-wheel omni kinematics pipeline
// request codes, register indexes, cordic gain and arctangent table; no dependencies
package otwk_pkg;

	localparam logic [2:0] MODE_FWD_BODY   = 3'd0;
	localparam logic [2:0] MODE_FWD_WORLD  = 3'd1;
	localparam logic [2:0] MODE_INV_BODY   = 3'd2;
	localparam logic [2:0] MODE_INV_WORLD  = 3'd3;
	localparam logic [2:0] MODE_BODY2WORLD = 3'd4;
	localparam logic [2:0] MODE_WORLD2BODY = 3'd5;

	localparam logic [1:0] REG_WHEEL_DISTANCE = 2'd0;
	localparam logic [1:0] REG_INV_THREE_DIST = 2'd1;

	localparam int MAX_STEPS = 24;

	localparam logic signed [31:0] CORDIC_K      = 32'sd652032875;
	localparam logic signed [16:0] INV_SQRT3_Q16 = 17'sd37837;
	localparam logic signed [20:0] HALF_SQRT3_Q20 = 21'sd908093;
	// ceil(2^24 / 3), exact floor division by three below 2^23
	localparam logic [22:0] RECIP3_Q24 = 23'd5592406;
	localparam logic [19:0] DIV3_BIAS  = 20'd786432;

	localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

endpackage

>>> rtl/omni_three_wheel_kinematics.sv
// three-omniwheel kinematics: wheel mix, inverse mix and frame rotation
// uses otwk_pkg; pipelined cordic for heading sine and cosine
//
//   channel | signals                          | role
//   in      | in_valid in_stall + fields       | one request beat
//   out     | out_valid out_stall + fields     | one result beat
//   cfg     | cfg_we cfg_index cfg_data        | register write
//
// one beat per cycle unless the output is stalled; a beat passes the input register,
// then the cordic stages, then the rotation and wheel mix stages
// reset clears all valid bits and loads the register defaults
// a stalled output beat holds the whole pipeline; in_stall follows it
module omni_three_wheel_kinematics #(
	parameter int SPEED_WIDTH  = 16,
	parameter int ROTATE_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic signed [15:0] yaw_rate,
	input  logic signed [15:0] wheel_left,
	input  logic signed [15:0] wheel_back,
	input  logic signed [15:0] wheel_right,
	input  logic signed [15:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_yaw,
	output logic signed [15:0] out_left,
	output logic signed [15:0] out_back,
	output logic signed [15:0] out_right
);

	localparam int N  = (ROTATE_STEPS > otwk_pkg::MAX_STEPS) ? otwk_pkg::MAX_STEPS : ROTATE_STEPS;
	localparam int SW = (SPEED_WIDTH < 16) ? SPEED_WIDTH : 16;
	localparam logic signed [43:0] SAT_HI = (44'sd1 <<< (SW - 1)) - 44'sd1;
	localparam logic signed [43:0] SAT_LO = -SAT_HI - 44'sd1;

	typedef struct packed {
		logic [2:0]         mode;
		logic               flip;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] w;
		logic [19:0]        mp;
		logic signed [16:0] d;
		logic signed [17:0] t;
		logic [42:0]        px;
		logic signed [33:0] py;
		logic signed [34:0] pw;
		logic signed [17:0] r0;
		logic signed [17:0] r1;
		logic signed [26:0] r2;
	} pay_t;

	function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
		logic signed [43:0] c;
		c = v;
		if (v > SAT_HI)
			c = SAT_HI;
		if (v < SAT_LO)
			c = SAT_LO;
		return c[15:0];
	endfunction

	logic [15:0] wd_q, inv3_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q   <= 16'd4096;
			inv3_q <= 16'd85;
		end else if (cfg_we) begin
			case (cfg_index)
				otwk_pkg::REG_WHEEL_DISTANCE: wd_q   <= cfg_data;
				otwk_pkg::REG_INV_THREE_DIST: inv3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: fold heading, wheel sums
	logic signed [18:0] wl19, wb19, wr19, s19;
	logic signed [20:0] m21;
	logic signed [16:0] a17, af17;
	logic               fold;
	pay_t               pin;
	pay_t               pay_s1;
	logic signed [31:0] z_s1;
	logic               v_s1;

	assign wl19 = 19'(wheel_left);
	assign wb19 = 19'(wheel_back);
	assign wr19 = 19'(wheel_right);
	assign s19  = (wb19 <<< 1) - wl19 - wr19;
	assign m21  = 21'(s19) + 21'sd1 + $signed({1'b0, otwk_pkg::DIV3_BIAS});
	assign a17  = 17'(heading);

	always_comb begin
		fold = 1'b0;
		af17 = a17;
		if (heading > 16'sd16384) begin
			af17 = a17 - 17'sd32768;
			fold = 1'b1;
		end else if (heading < -16'sd16384) begin
			af17 = a17 + 17'sd32768;
			fold = 1'b1;
		end
		pin      = '0;
		pin.mode = req_type;
		pin.flip = fold;
		pin.vx   = vel_x;
		pin.vy   = vel_y;
		pin.w    = yaw_rate;
		pin.mp   = m21[19:0];
		pin.d    = 17'(wheel_right) - 17'(wheel_left);
		pin.t    = 18'(wheel_left) + 18'(wheel_back) + 18'(wheel_right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= pin;
			z_s1   <= {af17[15:0], 16'd0};
		end
	end

	// stage 2: cordic iterations, forward mix rides along
	logic signed [31:0] cx_s2 [N];
	logic signed [31:0] cy_s2 [N];
	logic signed [31:0] cz_s2 [N];
	pay_t               pay_s2 [N];
	logic               v_s2 [N];

	for (genvar k = 0; k < N; k++) begin : g_cor
		logic signed [31:0] xi, yi, zi, xo, yo, zo;
		pay_t               pi, po;
		logic               vi;
		if (k == 0) begin : g_first
			assign xi = otwk_pkg::CORDIC_K;
			assign yi = '0;
			assign zi = z_s1;
			assign pi = pay_s1;
			assign vi = v_s1;
		end else begin : g_next
			assign xi = cx_s2[k-1];
			assign yi = cy_s2[k-1];
			assign zi = cz_s2[k-1];
			assign pi = pay_s2[k-1];
			assign vi = v_s2[k-1];
		end

		always_comb begin
			if (zi >= 0) begin
				xo = xi - (yi >>> k);
				yo = yi + (xi >>> k);
				zo = zi - $signed(otwk_pkg::ATAN_TAB[k]);
			end else begin
				xo = xi + (yi >>> k);
				yo = yi - (xi >>> k);
				zo = zi + $signed(otwk_pkg::ATAN_TAB[k]);
			end
			po = pi;
			if (k == 0) begin
				po.px = 43'(pi.mp) * 43'(otwk_pkg::RECIP3_Q24);
				po.py = 34'(pi.d) * 34'(otwk_pkg::INV_SQRT3_Q16);
				po.pw = 35'(pi.t) * 35'($signed({1'b0, inv3_q}));
			end
			if (k == 1) begin
				po.r0 = 18'($signed({1'b0, pi.px[42:24]}) - 20'sd262144);
				po.r1 = 18'((pi.py + 34'sd32768) >>> 16);
				po.r2 = 27'((pi.pw + 35'sd128) >>> 8);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s2[k] <= 1'b0;
			else if (en)
				v_s2[k] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s2[k]  <= xo;
				cy_s2[k]  <= yo;
				cz_s2[k]  <= zo;
				pay_s2[k] <= po;
			end
		end
	end

	// stage 3: rotation products
	pay_t               pl;
	logic signed [31:0] cc, ss;
	logic signed [17:0] rx, ry;
	logic signed [49:0] pcx_s3, psy_s3, psx_s3, pcy_s3;
	pay_t               pay_s3;
	logic               v_s3;

	assign pl = pay_s2[N-1];

	always_comb begin
		cc = pl.flip ? -cx_s2[N-1] : cx_s2[N-1];
		ss = pl.flip ? -cy_s2[N-1] : cy_s2[N-1];
		if (pl.mode == otwk_pkg::MODE_INV_WORLD || pl.mode == otwk_pkg::MODE_WORLD2BODY)
			ss = -ss;
		if (pl.mode == otwk_pkg::MODE_FWD_WORLD) begin
			rx = pl.r0;
			ry = pl.r1;
		end else begin
			rx = 18'(pl.vx);
			ry = 18'(pl.vy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2[N-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcx_s3 <= 50'(cc) * 50'(rx);
			psy_s3 <= 50'(ss) * 50'(ry);
			psx_s3 <= 50'(ss) * 50'(rx);
			pcy_s3 <= 50'(cc) * 50'(ry);
			pay_s3 <= pl;
		end
	end

	// stage 4: round rotation, pick vectors
	logic signed [50:0] sumx, sumy;
	logic signed [20:0] rotx, roty;
	logic signed [20:0] ux_s4, uy_s4, qx_s4, qy_s4;
	logic signed [26:0] r2_s4;
	logic signed [15:0] w_s4;
	logic [2:0]         mode_s4;
	logic               v_s4;

	assign sumx = 51'(pcx_s3) - 51'(psy_s3) + 51'sd536870912;
	assign sumy = 51'(psx_s3) + 51'(pcy_s3) + 51'sd536870912;
	assign rotx = sumx[50:30];
	assign roty = sumy[50:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pay_s3.mode == otwk_pkg::MODE_INV_WORLD) begin
				ux_s4 <= rotx;
				uy_s4 <= roty;
			end else begin
				ux_s4 <= 21'(pay_s3.vx);
				uy_s4 <= 21'(pay_s3.vy);
			end
			if (pay_s3.mode == otwk_pkg::MODE_FWD_BODY) begin
				qx_s4 <= 21'(pay_s3.r0);
				qy_s4 <= 21'(pay_s3.r1);
			end else begin
				qx_s4 <= rotx;
				qy_s4 <= roty;
			end
			r2_s4   <= pay_s3.r2;
			w_s4    <= pay_s3.w;
			mode_s4 <= pay_s3.mode;
		end
	end

	// stage 5: inverse mix products
	logic signed [41:0] b_s5;
	logic signed [32:0] lw_s5;
	logic signed [20:0] ux_s5, qx_s5, qy_s5;
	logic signed [26:0] r2_s5;
	logic [2:0]         mode_s5;
	logic               v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s5    <= 42'(uy_s4) * 42'(otwk_pkg::HALF_SQRT3_Q20);
			lw_s5   <= 33'($signed({1'b0, wd_q})) * 33'(w_s4);
			ux_s5   <= ux_s4;
			qx_s5   <= qx_s4;
			qy_s5   <= qy_s4;
			r2_s5   <= r2_s4;
			mode_s5 <= mode_s4;
		end
	end

	// stage 6: wheel sums, saturate, output register
	logic signed [43:0] av, bv, lv, half, sl, sb, sr;
	logic signed [15:0] ox, oy, oyaw, ol, ob, orr;
	logic signed [15:0] x_s6, y_s6, yaw_s6, left_s6, back_s6, right_s6;
	logic               v_s6;

	always_comb begin
		av   = 44'(ux_s5) <<< 19;
		bv   = 44'(b_s5);
		lv   = 44'(lw_s5) <<< 8;
		half = 44'sd524288;
		sl   = (-av - bv + lv + half) >>> 20;
		sb   = ((av <<< 1) + lv + half) >>> 20;
		sr   = (-av + bv + lv + half) >>> 20;
		ox   = '0;
		oy   = '0;
		oyaw = '0;
		ol   = '0;
		ob   = '0;
		orr  = '0;
		case (mode_s5) inside
			otwk_pkg::MODE_FWD_BODY, otwk_pkg::MODE_FWD_WORLD: begin
				ox   = sat16(44'(qx_s5));
				oy   = sat16(44'(qy_s5));
				oyaw = sat16(44'(r2_s5));
			end
			otwk_pkg::MODE_INV_BODY, otwk_pkg::MODE_INV_WORLD: begin
				ol  = sat16(sl);
				ob  = sat16(sb);
				orr = sat16(sr);
			end
			otwk_pkg::MODE_BODY2WORLD, otwk_pkg::MODE_WORLD2BODY: begin
				ox = sat16(44'(qx_s5));
				oy = sat16(44'(qy_s5));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6     <= ox;
			y_s6     <= oy;
			yaw_s6   <= oyaw;
			left_s6  <= ol;
			back_s6  <= ob;
			right_s6 <= orr;
		end
	end

	assign en        = !(v_s6 && out_stall);
	assign in_stall  = v_s6 && out_stall;
	assign out_valid = v_s6;
	assign out_x     = x_s6;
	assign out_y     = y_s6;
	assign out_yaw   = yaw_s6;
	assign out_left  = left_s6;
	assign out_back  = back_s6;
	assign out_right = right_s6;

endmodule

>>> rtl/otwk_checker.sv
// port-level checks for the kinematics block, bound to the top level
// uses omni_three_wheel_kinematics_macros.svh
`include "omni_three_wheel_kinematics_macros.svh"

module otwk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_yaw,
	input logic signed [15:0] out_left,
	input logic signed [15:0] out_back,
	input logic signed [15:0] out_right
);

	logic [95:0] res_bits;
	assign res_bits = {out_x, out_y, out_yaw, out_left, out_back, out_right};

	`OTWK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output beat dropped under stall")
	`OTWK_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(res_bits), "output beat changed")
	`OTWK_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held output")
	`OTWK_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !out_valid, "output beat right after reset")

endmodule

bind omni_three_wheel_kinematics otwk_checker u_otwk_checker (.*);

>>> test/tb_top.sv
// self-checking bench for omni_three_wheel_kinematics: directed table then random beats
// depends on otwk_pkg and the rtl; predicts or looks up each result, compares field by field
`timescale 1ns / 100ps

module tb_top;

	localparam int N_STEPS = 16;
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [2:0] mode;
		shortint vx, vy, w, wl, wb, wr, h;
	} kin_req_t;

	typedef struct {
		shortint x, y, yaw, l, b, r;
	} kin_res_t;

	typedef struct {
		kin_req_t req;
		bit typed;
		kin_res_t res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic signed [15:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
	logic signed [15:0] wheel_left = '0, wheel_back = '0, wheel_right = '0, heading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_x, out_y, out_yaw, out_left, out_back, out_right;

	longint unsigned dist_q412 = 4096;
	longint unsigned inv3_q88 = 85;
	kin_res_t pending[$];
	table_row_t directed[$];
	int errors = 0;
	int cycles = 0;
	bit hold_req = 0;
	bit quiet = 0;

	omni_three_wheel_kinematics DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic shortint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return shortint'(v);
	endfunction

	function automatic void heading_sincos(longint a, output longint c, output longint s);
		bit flip;
		longint x, y, z, t;
		flip = 0;
		x = otwk_pkg::CORDIC_K;
		y = 0;
		if (a > 16384) begin
			a -= 32768;
			flip = 1;
		end else if (a < -16384) begin
			a += 32768;
			flip = 1;
		end
		z = a * 65536;
		for (int i = 0; i < N_STEPS; i++) begin
			t = x;
			if (z >= 0) begin
				x -= y >>> i;
				y += t >>> i;
				z -= longint'(otwk_pkg::ATAN_TAB[i]);
			end else begin
				x += y >>> i;
				y -= t >>> i;
				z += longint'(otwk_pkg::ATAN_TAB[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void frame_rotate(longint h, bit to_body, longint x, longint y,
			output longint ox, output longint oy);
		longint c, s;
		heading_sincos(h, c, s);
		if (to_body) s = -s;
		ox = round_shift(c * x - s * y, 30);
		oy = round_shift(s * x + c * y, 30);
	endfunction

	function automatic kin_res_t kin_predict(kin_req_t q);
		longint r[6];
		longint vx, vy, a, b, lw, num;
		kin_res_t o;
		foreach (r[k]) r[k] = 0;
		vx = q.vx;
		vy = q.vy;
		case (q.mode)
			otwk_pkg::MODE_FWD_BODY, otwk_pkg::MODE_FWD_WORLD: begin
				num = 2 * (2 * longint'(q.wb) - q.wl - q.wr) + 3;
				r[0] = (num >= 0) ? num / 6 : -((-num + 5) / 6);
				r[1] = round_shift((longint'(q.wr) - q.wl) * 37837, 16);
				r[2] = round_shift((longint'(q.wl) + q.wb + q.wr) * longint'(inv3_q88), 8);
				if (q.mode == otwk_pkg::MODE_FWD_WORLD)
					frame_rotate(q.h, 0, r[0], r[1], r[0], r[1]);
			end
			otwk_pkg::MODE_INV_BODY, otwk_pkg::MODE_INV_WORLD: begin
				if (q.mode == otwk_pkg::MODE_INV_WORLD) frame_rotate(q.h, 1, vx, vy, vx, vy);
				a = vx * 524288;
				b = vy * 908093;
				lw = longint'(dist_q412) * q.w * 256;
				r[3] = round_shift(-a - b + lw, 20);
				r[4] = round_shift(vx * 1048576 + lw, 20);
				r[5] = round_shift(-a + b + lw, 20);
			end
			otwk_pkg::MODE_BODY2WORLD, otwk_pkg::MODE_WORLD2BODY:
				frame_rotate(q.h, q.mode == otwk_pkg::MODE_WORLD2BODY, vx, vy, r[0], r[1]);
			default: ;
		endcase
		o.x = clamp16(r[0]);
		o.y = clamp16(r[1]);
		o.yaw = clamp16(r[2]);
		o.l = clamp16(r[3]);
		o.b = clamp16(r[4]);
		o.r = clamp16(r[5]);
		return o;
	endfunction

	task automatic check_field(string name, shortint exp, logic signed [15:0] act);
		if (act !== exp) begin
			$error("%s expected %0d got %0d", name, exp, act);
			errors++;
		end
	endtask

	// result side
	always @(posedge clk) begin
		kin_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("result beat with nothing pending");
				errors++;
			end else begin
				e = pending.pop_front();
				check_field("out_x", e.x, out_x);
				check_field("out_y", e.y, out_y);
				check_field("out_yaw", e.yaw, out_yaw);
				check_field("out_left", e.l, out_left);
				check_field("out_back", e.b, out_back);
				check_field("out_right", e.r, out_right);
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (held = 0; held < 300; held++) @(posedge clk);
				hold_req = 0;
			end
			out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);
		end
	end

	task automatic send_beat(kin_req_t q, bit typed, kin_res_t res);
		req_type <= q.mode;
		vel_x <= q.vx;
		vel_y <= q.vy;
		yaw_rate <= q.w;
		wheel_left <= q.wl;
		wheel_back <= q.wb;
		wheel_right <= q.wr;
		heading <= q.h;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending.push_back(typed ? res : kin_predict(q));
		if (!quiet && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == otwk_pkg::REG_WHEEL_DISTANCE) dist_q412 = val;
		else if (idx == otwk_pkg::REG_INV_THREE_DIST) inv3_q88 = val;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic shortint rand_speed();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return shortint'($urandom_range(512)) - 256;
			default: return shortint'($urandom);
		endcase
	endfunction

	function automatic kin_req_t rand_req();
		kin_req_t q;
		q.mode = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		q.vx = rand_speed();
		q.vy = rand_speed();
		q.w = rand_speed();
		q.wl = rand_speed();
		q.wb = rand_speed();
		q.wr = rand_speed();
		q.h = shortint'($urandom);
		return q;
	endfunction

	task automatic add_row(logic [2:0] m, shortint vx, shortint vy, shortint w, shortint wl,
			shortint wb, shortint wr, shortint h, bit typed, kin_res_t res);
		table_row_t t;
		t.req = '{m, vx, vy, w, wl, wb, wr, h};
		t.typed = typed;
		t.res = res;
		directed.push_back(t);
	endtask

	initial begin
		kin_res_t zero, inv_min;
		kin_res_t none;
		zero = '{0, 0, 0, 0, 0, 0};
		none = zero;
		inv_min = '{0, 0, 0, 16384, -32768, 16384};
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, 0, 0, 0, 0, 1, zero);
		add_row(MODE_BAD_LO, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 1, zero);
		add_row(MODE_BAD_HI, -1, -1, -1, -1, -1, -1, -1, 1, zero);
		add_row(otwk_pkg::MODE_INV_BODY, -32768, 0, 0, 0, 0, 0, 0, 1, inv_min);
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, 32767, 32767, 32767, 0, 0, none);
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, -32768, -32768, -32768, 0, 0, none);
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, -32768, 32767, 32767, 0, 0, none);
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, 1, 0, 0, 0, 0, none);
		add_row(otwk_pkg::MODE_FWD_BODY, 0, 0, 0, -1, 0, -1, 0, 0, none);
		add_row(otwk_pkg::MODE_FWD_WORLD, 0, 0, 0, -256, 512, 256, 16384, 0, none);
		add_row(otwk_pkg::MODE_FWD_WORLD, 0, 0, 0, 32767, -32768, 0, -32768, 0, none);
		add_row(otwk_pkg::MODE_INV_BODY, 32767, 32767, 32767, 0, 0, 0, 0, 0, none);
		add_row(otwk_pkg::MODE_INV_BODY, 0, -32768, -32768, 0, 0, 0, 0, 0, none);
		add_row(otwk_pkg::MODE_INV_WORLD, 256, 0, 256, 0, 0, 0, 32767, 0, none);
		add_row(otwk_pkg::MODE_INV_WORLD, -32768, 32767, 0, 0, 0, 0, -16384, 0, none);
		add_row(otwk_pkg::MODE_BODY2WORLD, 32767, 32767, 0, 0, 0, 0, 16385, 0, none);
		add_row(otwk_pkg::MODE_BODY2WORLD, 256, 0, 0, 0, 0, 0, -16385, 0, none);
		add_row(otwk_pkg::MODE_BODY2WORLD, -32768, -32768, 0, 0, 0, 0, 8192, 0, none);
		add_row(otwk_pkg::MODE_WORLD2BODY, 256, 512, 0, 0, 0, 0, 16384, 0, none);
		add_row(otwk_pkg::MODE_WORLD2BODY, 32767, -32768, 0, 0, 0, 0, -32768, 0, none);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_beat(directed[i].req, directed[i].typed, directed[i].res);
		wait_idle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(otwk_pkg::REG_WHEEL_DISTANCE, 16'd1);
					write_reg(otwk_pkg::REG_INV_THREE_DIST, 16'd0);
				end
				1: begin
					write_reg(otwk_pkg::REG_WHEEL_DISTANCE, 16'hffff);
					write_reg(otwk_pkg::REG_INV_THREE_DIST, 16'hffff);
					write_reg(REG_SPARE_LO, 16'h1234);
				end
				2: begin
					write_reg(otwk_pkg::REG_WHEEL_DISTANCE, 16'($urandom));
					write_reg(otwk_pkg::REG_INV_THREE_DIST, 16'($urandom));
					write_reg(REG_SPARE_HI, 16'($urandom));
				end
				default: begin
					write_reg(otwk_pkg::REG_WHEEL_DISTANCE, 16'd4096);
					write_reg(otwk_pkg::REG_INV_THREE_DIST, 16'd85);
				end
			endcase
			for (int n = 0; n < 185; n++) begin
				if (phase == 1 && n == 20) hold_req = 1;
				if (phase == 2 && n == 60) wait_idle();
				quiet = (phase == 3 && n >= 40 && n < 120);
				send_beat(rand_req(), 0, zero);
			end
			quiet = 0;
			wait_idle();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/otwk_pkg.sv
rtl/omni_three_wheel_kinematics.sv
rtl/otwk_checker.sv
test/tb_top.sv
